// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

    // Default number of cells in the chain.
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_SEARCH     = 2'd3
    } kind_t;

    // Status codes returned with every item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Command broadcast from the control to every cell.
    typedef struct packed {
        logic               take;
        logic               front_en;
        logic               back_en;
        logic               grow;
        logic               shrink;
        logic               search;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== hdl/bdq_if.sv =====
// Request channel: one operation per item.
interface bdq_req_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::KIND_W-1:0]         kind;
    logic signed [bdq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// Response channel: one result item per operation.
interface bdq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [bdq_pkg::COUNT_W-1:0]  count;
    logic                         empty_res;
    logic [bdq_pkg::STATUS_W-1:0] status;

    modport source (output valid, output found, output count, output empty_res,
                    output status, input ready);
    modport sink   (input valid, input found, input count, input empty_res,
                    input status, output ready);
endinterface

// ===== hdl/bdq_cell.sv =====
module bdq_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdq_pkg::cell_cmd_t            cmd,
    input  logic [bdq_pkg::VALUE_W-1:0]   left_data,
    input  logic                          left_occ,
    input  logic                          right_occ,
    output logic [bdq_pkg::VALUE_W-1:0]   data,
    output logic                          occ,
    output logic                          match
);

    logic [bdq_pkg::VALUE_W-1:0] data_reg;
    logic [bdq_pkg::VALUE_W-1:0] data_next;
    logic                        occ_reg;
    logic                        occ_next;
    logic                        match_reg;
    logic                        match_next;

    // Next contents: shift right on a front insert, load at the first free
    // cell on a back insert; occupancy is a thermometer that grows from the
    // front and shrinks from the back.
    always_comb
    begin
        data_next  = data_reg;
        occ_next   = occ_reg;
        match_next = match_reg;
        if (cmd.front_en)
        begin
            data_next = left_data;
        end
        else if (cmd.back_en && !occ_reg && left_occ)
        begin
            data_next = cmd.value;
        end
        if (cmd.grow)
        begin
            occ_next = left_occ;
        end
        else if (cmd.shrink)
        begin
            occ_next = right_occ;
        end
        if (cmd.take)
        begin
            match_next = cmd.search && occ_reg && (data_reg == cmd.value);
        end
    end

    // The stored value needs no reset: it is read only once occupied.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign match = match_reg;

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
// Channel  Dir  Fields                              Handshake
// req      in   kind[1:0], value[31:0] signed       valid/ready
// rsp      out  found, count[4:0], empty_res,       valid/ready
//               status[1:0]
//
// An operation is taken by the row of cells, which register their match
// bits; once the output register is free, the registered match bits of all
// cells are ORed and the result item is loaded into the output register.
// One item per cycle is sustained while rsp is not stalled; the compare
// stage holds one item, so req stalls only while that stage waits on rsp.
// Reset clears the count, all occupancy bits and both valid flags at once.
module bounded_deque_with_search
#(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = CW + bdq_pkg::COUNT_W;

    bdq_pkg::cell_cmd_t            cmd;
    bdq_pkg::kind_t                kind;
    bdq_pkg::status_t              status_op;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 cnt_next;
    logic                          full;
    logic                          take;
    logic                          out_free;

    logic                          pend_reg;
    logic                          pend_next;
    logic [CW-1:0]                 pend_cnt_reg;
    bdq_pkg::status_t              pend_status_reg;

    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic                          found_reg;
    logic [bdq_pkg::COUNT_W-1:0]   count_reg;
    logic                          empty_reg;
    bdq_pkg::status_t              status_reg;
    logic [EXT_W-1:0]              cnt_ext;

    logic [bdq_pkg::VALUE_W-1:0]   data_w [DEPTH];
    logic [DEPTH-1:0]              occ_w;
    logic [DEPTH-1:0]              match_w;

    // Handshake.
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = !pend_reg || out_free;
    assign take      = req.valid && req.ready;
    assign full      = (cnt_reg == CW'(DEPTH));
    assign kind      = bdq_pkg::kind_t'(req.kind);

    // Decode the operation into a command for the cells and the new count.
    always_comb
    begin
        cmd          = '0;
        cmd.take     = take;
        cmd.value    = req.value;
        cnt_next     = cnt_reg;
        status_op    = bdq_pkg::ST_OK;
        case (kind)
            bdq_pkg::KIND_PUSH_FRONT,
            bdq_pkg::KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    status_op = bdq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.front_en = take && (kind == bdq_pkg::KIND_PUSH_FRONT);
                    cmd.back_en  = take && (kind == bdq_pkg::KIND_PUSH_BACK);
                    cmd.grow     = take;
                    if (take)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            bdq_pkg::KIND_POP_BACK:
            begin
                if (cnt_reg == '0)
                begin
                    status_op = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.shrink = take;
                    if (take)
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            bdq_pkg::KIND_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            default:
            begin
                status_op = bdq_pkg::ST_OK;
            end
        endcase
    end

    // The row of cells; the front cell is fed from the request, the back
    // cell sees an empty neighbour.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bdq_pkg::VALUE_W-1:0] left_data;
        logic                        left_occ;
        logic                        right_occ;

        if (i == 0)
        begin : g_front
            assign left_data = req.value;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_inner
            assign left_data = data_w[i-1];
            assign left_occ  = occ_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_occ = 1'b0;
        end
        else
        begin : g_mid
            assign right_occ = occ_w[i+1];
        end

        bdq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_data (left_data),
            .left_occ  (left_occ),
            .right_occ (right_occ),
            .data      (data_w[i]),
            .occ       (occ_w[i]),
            .match     (match_w[i])
        );
    end

    // Compare stage: holds the item while the cells' match bits settle.
    always_comb
    begin
        pend_next = pend_reg;
        if (take)
        begin
            pend_next = 1'b1;
        end
        else if (out_free)
        begin
            pend_next = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (pend_reg && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign cnt_ext = EXT_W'(pend_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_cnt_reg    <= cnt_next;
            pend_status_reg <= status_op;
        end
        if (pend_reg && out_free)
        begin
            found_reg  <= |match_w;
            count_reg  <= cnt_ext[bdq_pkg::COUNT_W-1:0];
            empty_reg  <= (pend_cnt_reg == '0);
            status_reg <= pend_status_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = found_reg;
    assign rsp.count     = count_reg;
    assign rsp.empty_res = empty_reg;
    assign rsp.status    = status_reg;

`ifndef SYNTH
    // The count never passes the number of cells.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // Occupancy bits of the cells agree with the count.
    a_occ_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_w) == int'(cnt_reg))
        else $error("cell occupancy disagrees with count");

    // A dropped insert is only ever reported with a full store.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && pend_status_reg == bdq_pkg::ST_FULL |-> pend_cnt_reg == CW'(DEPTH))
        else $error("insert dropped while not full");

    // A found value implies a non-empty store.
    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && found_reg |-> !empty_reg)
        else $error("found reported on empty store");

    // A stalled result item leaves the compare stage waiting.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && rsp_valid_reg && !rsp.ready |=> pend_reg)
        else $error("compare stage lost an item under stall");
`endif

endmodule

// ===== tb/tb_bounded_deque_with_search.sv =====
module tb_bounded_deque_with_search;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = bdq_pkg::DEPTH_DEFAULT;
    localparam int DIR_ROWS   = 25;
    localparam int RAND_ITEMS = 210;
    localparam int CYCLE_CAP  = 250000;

    // One result item as the block reports it.
    typedef struct packed {
        logic                        found;
        logic [bdq_pkg::COUNT_W-1:0] count;
        logic                        empty_res;
        bdq_pkg::status_t            status;
    } deque_rsp_t;

    // One row of the directed table; fixed_rsp is used only where has_fixed is set.
    typedef struct {
        bdq_pkg::kind_t      kind;
        logic signed [31:0]  value;
        bit                  has_fixed;
        deque_rsp_t          fixed_rsp;
    } op_row_t;

    localparam deque_rsp_t NO_RSP = '{1'b0, 5'd0, 1'b0, bdq_pkg::ST_OK};

    logic clk;
    logic rst_n;

    bdq_req_if req ();
    bdq_rsp_if rsp ();

    bounded_deque_with_search #(.DEPTH(DEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the stored sequence, front at index 0.
    logic signed [31:0] shadow_vals [$];
    deque_rsp_t         pending_outcomes [$];
    int                 mismatches;
    int                 feed_idle_pct;
    int                 drain_idle_pct;
    int                 cycle_cnt;

    // Directed table: empty-store cases, field extremes, fill to full, inserts when full.
    op_row_t directed_ops [DIR_ROWS] = '{
        '{bdq_pkg::KIND_POP_BACK,   32'sh0000_0000, 1'b1, '{1'b0, 5'd0,  1'b1, bdq_pkg::ST_EMPTY}},
        '{bdq_pkg::KIND_SEARCH,     32'sh0000_0000, 1'b1, '{1'b0, 5'd0,  1'b1, bdq_pkg::ST_OK}},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, '{1'b0, 5'd1,  1'b0, bdq_pkg::ST_OK}},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000, 1'b1, '{1'b0, 5'd2,  1'b0, bdq_pkg::ST_OK}},
        '{bdq_pkg::KIND_SEARCH,     32'sh8000_0000, 1'b1, '{1'b1, 5'd2,  1'b0, bdq_pkg::ST_OK}},
        '{bdq_pkg::KIND_POP_BACK,   32'shFFFF_FFFF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_SEARCH,     32'sh7FFF_FFFF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'shFFFF_FFFF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh0000_0000, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh0000_0001, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh5555_5555, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'shAAAA_AAAA, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh0000_0001, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh1234_5678, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'shDEAD_BEEF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh7FFF_FFFF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh8000_0001, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh0F0F_0F0F, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'shF0F0_F0F0, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh0000_00FF, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'shFFFF_FF00, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh0000_0002, 1'b0, NO_RSP},
        '{bdq_pkg::KIND_PUSH_BACK,  32'sh0000_0003, 1'b1, '{1'b0, 5'd16, 1'b0, bdq_pkg::ST_FULL}},
        '{bdq_pkg::KIND_PUSH_FRONT, 32'sh0000_0004, 1'b1, '{1'b0, 5'd16, 1'b0, bdq_pkg::ST_FULL}},
        '{bdq_pkg::KIND_SEARCH,     32'sh0000_0002, 1'b1, '{1'b1, 5'd16, 1'b0, bdq_pkg::ST_OK}}
    };

    // Applies one operation to the shadow sequence and returns the result item it gives.
    function automatic deque_rsp_t deque_outcome(input bdq_pkg::kind_t k,
                                                 input logic signed [31:0] v);
        deque_rsp_t r;
        r = NO_RSP;
        case (k)
            bdq_pkg::KIND_PUSH_FRONT:
                if (shadow_vals.size() >= DEPTH)
                    r.status = bdq_pkg::ST_FULL;
                else
                    shadow_vals.push_front(v);
            bdq_pkg::KIND_PUSH_BACK:
                if (shadow_vals.size() >= DEPTH)
                    r.status = bdq_pkg::ST_FULL;
                else
                    shadow_vals.push_back(v);
            bdq_pkg::KIND_POP_BACK:
                if (shadow_vals.size() == 0)
                    r.status = bdq_pkg::ST_EMPTY;
                else
                    void'(shadow_vals.pop_back());
            default:
                foreach (shadow_vals[i])
                begin
                    if (shadow_vals[i] == v)
                        r.found = 1'b1;
                end
        endcase
        r.count     = bdq_pkg::COUNT_W'(shadow_vals.size());
        r.empty_res = (shadow_vals.size() == 0);
        return r;
    endfunction

    // Random value: a small pool for duplicates, the extremes, or anything at all.
    function automatic logic signed [31:0] random_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return $signed(32'($urandom_range(7))) - 32'sd4;
        else if (sel == 3)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            return $urandom;
    endfunction

    // Operation mix for a burst: growing, shrinking or balanced.
    function automatic bdq_pkg::kind_t random_kind(input int mode);
        int             roll;
        bdq_pkg::kind_t push_kind;
        roll      = $urandom_range(99);
        push_kind = $urandom_range(1) ? bdq_pkg::KIND_PUSH_FRONT : bdq_pkg::KIND_PUSH_BACK;
        if (roll < 25)
            return bdq_pkg::KIND_SEARCH;
        if (mode == 0)
            return (roll < 35) ? bdq_pkg::KIND_POP_BACK : push_kind;
        if (mode == 1)
            return (roll < 85) ? bdq_pkg::KIND_POP_BACK : push_kind;
        return (roll < 55) ? bdq_pkg::KIND_POP_BACK : push_kind;
    endfunction

    task automatic report_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // Presents one item on req, waits for it to be taken and records what should come back.
    task automatic issue_op(input bdq_pkg::kind_t k, input logic signed [31:0] v,
                            input bit has_fixed, input deque_rsp_t fixed_rsp);
        deque_rsp_t predicted;
        while ($urandom_range(99) < feed_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind  <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = deque_outcome(k, v);
        pending_outcomes.push_back(has_fixed ? fixed_rsp : predicted);
        @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle limit.
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver: stalls rsp at the rate of the current phase.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        deque_rsp_t want;
        deque_rsp_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.found, rsp.count, rsp.empty_res, bdq_pkg::status_t'(rsp.status)};
            if (pending_outcomes.size() == 0)
            begin
                report_fault($sformatf({"unexpected result item: found=%0b count=%0d ",
                                        "empty=%0b status=%0d"},
                                       got.found, got.count, got.empty_res, got.status));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.found != want.found || got.count != want.count ||
                    got.empty_res != want.empty_res || got.status != want.status)
                    report_fault($sformatf({"result mismatch: expected found=%0b count=%0d ",
                                            "empty=%0b status=%0d, got found=%0b count=%0d ",
                                            "empty=%0b status=%0d"},
                                           want.found, want.count, want.empty_res, want.status,
                                           got.found, got.count, got.empty_res, got.status));
            end
        end
    end

    // Stimulus.
    initial
    begin
        bdq_pkg::kind_t     k;
        logic signed [31:0] v;
        int                 mode;

        mismatches     = 0;
        feed_idle_pct  = 37;
        drain_idle_pct = 84;
        mode           = 2;
        rst_n          = 1'b0;
        req.valid     <= 1'b0;
        req.kind      <= bdq_pkg::KIND_PUSH_FRONT;
        req.value     <= 32'sd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        foreach (directed_ops[i])
            issue_op(directed_ops[i].kind, directed_ops[i].value,
                     directed_ops[i].has_fixed, directed_ops[i].fixed_rsp);

        // Random phases: the receiver idles heavily, then the sender, then neither idles.
        for (int phase = 0; phase < 3; phase++)
        begin
            feed_idle_pct  = (phase == 0) ? 37 : (phase == 1) ? 84 : 0;
            drain_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 37 : 0;
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                if (n % 24 == 0)
                    mode = $urandom_range(2);
                k = random_kind(mode);
                v = random_value();
                // Searches mostly look for something that is stored.
                if (k == bdq_pkg::KIND_SEARCH && shadow_vals.size() != 0 &&
                    $urandom_range(99) < 60)
                    v = shadow_vals[$urandom_range(shadow_vals.size() - 1)];
                issue_op(k, v, 1'b0, NO_RSP);
            end
        end
        req.valid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
